### sv/rshd_pkg.sv
// Package with shared constants and types of the radial shell density histogram.
package rshd_pkg;

    localparam int MAX_BINS   = 32;
    localparam int BIN_W      = $clog2(MAX_BINS);
    localparam int SLOT_W     = 6;
    localparam int RADIUS_W   = 20;
    localparam int WEIGHT_W   = 24;
    localparam int SUM_W      = 48;
    localparam int AREA_W     = 32;
    localparam int COUNT_W    = 6;
    localparam int DENS_W     = 64;
    localparam int CUBE_W     = 60;
    localparam int HALF_W     = CUBE_W / 2;
    localparam int DEN_W      = CUBE_W + AREA_W;
    localparam int NUM_W      = 128;
    localparam int DIV_CNT_W  = 7;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_EMIT   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [0:0] CFG_SKY_AREA  = 1'b0;
    localparam logic [0:0] CFG_BIN_COUNT = 1'b1;

    localparam logic [AREA_W-1:0]  SKY_AREA_RESET  = 32'd3373259426;
    localparam logic [COUNT_W-1:0] BIN_COUNT_RESET = 6'd32;

endpackage

### sv/rshd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rshd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/radial_shell_density_histogram.sv
// Top level of the radial shell density histogram.
//
// Items arrive on the s_ stream: cmd 0 loads one bin edge, cmd 1 adds a
// galaxy weight to its radial bin, cmd 2 emits one density per bin in use
// and clears all counts. Results leave on the m_ stream, one item per bin,
// with m_tlast on the final bin of an emit run.
// A load stores its bin edge at the accepting edge. An add compares the edges,
// which sit in flip-flops, in parallel at the accepting edge; then the count
// memory is read, summed and written back, and s_tready returns after the
// write-back. An emit runs per bin through edge and count fetch, two cube
// steps, two steps on a shared 30 x 32 multiplier for the volume times the sky
// area, 128 steps of a restoring divider that yields one quotient bit per
// cycle, and the output load. s_tready returns once the last bin has gone
// to the output register and the counts are cleared.
// After reset all counts read as zero through per-bin valid bits; sky_area
// and bin_count take their reset values and edges are undefined until loaded.
// When the receiver stalls, a finished result waits in the output register
// while the next bin is computed; the run pauses only when that next result
// is ready and the register is still full. s_tready stays low until the whole
// command is done. Configuration writes are taken at any edge with cfg_we high.
module radial_shell_density_histogram (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[1:0], edge_slot[7:2], edge_radius[27:8], galaxy_radius[47:28],
    // galaxy_weight[71:48]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bin_index[4:0], density[68:5], zero fill above
    output logic [71:0] m_tdata,
    // volume_fault, zero sky area or density overflow
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_ARD   = 11'b00000000010,
        ST_AWR   = 11'b00000000100,
        ST_ERD   = 11'b00000001000,
        ST_CUBE1 = 11'b00000010000,
        ST_CUBE2 = 11'b00000100000,
        ST_DEN   = 11'b00001000000,
        ST_DEN2  = 11'b00010000000,
        ST_DIV   = 11'b00100000000,
        ST_OUT   = 11'b01000000000,
        ST_WAIT  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [rshd_pkg::AREA_W-1:0]   sky_area_reg;
    logic [rshd_pkg::COUNT_W-1:0]  bin_count_reg;
    logic [rshd_pkg::RADIUS_W-1:0] edge_reg [rshd_pkg::MAX_BINS+1];
    logic [rshd_pkg::MAX_BINS-1:0] valid_reg;

    // Input field split.
    logic [1:0]                    in_cmd;
    logic [rshd_pkg::SLOT_W-1:0]   in_slot;
    logic [rshd_pkg::RADIUS_W-1:0] in_edge;
    logic [rshd_pkg::RADIUS_W-1:0] in_radius;
    logic [rshd_pkg::WEIGHT_W-1:0] in_weight;
    assign in_cmd    = s_tdata[1:0];
    assign in_slot   = s_tdata[7:2];
    assign in_edge   = s_tdata[27:8];
    assign in_radius = s_tdata[47:28];
    assign in_weight = s_tdata[71:48];

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Bins in use, clamped to 1..MAX_BINS.
    logic [rshd_pkg::COUNT_W-1:0] nb;
    always_comb begin
        nb = bin_count_reg;
        if (nb == '0) begin
            nb = rshd_pkg::COUNT_W'(1);
        end else if (nb > rshd_pkg::COUNT_W'(rshd_pkg::MAX_BINS)) begin
            nb = rshd_pkg::COUNT_W'(rshd_pkg::MAX_BINS);
        end
    end

    // Parallel edge compare: first bin whose upper edge exceeds the radius.
    logic                      hit;
    logic [rshd_pkg::BIN_W-1:0] hit_bin;
    always_comb begin
        hit     = 1'b0;
        hit_bin = '0;
        for (int i = rshd_pkg::MAX_BINS - 1; i >= 0; i--) begin
            if ((rshd_pkg::COUNT_W'(i) < nb) && (in_radius < edge_reg[i+1])) begin
                hit     = 1'b1;
                hit_bin = rshd_pkg::BIN_W'(i);
            end
        end
        if (in_radius < edge_reg[0]) begin
            hit = 1'b0;
        end
    end

    // Count memory.
    logic                       ram_we;
    logic [rshd_pkg::BIN_W-1:0] ram_waddr, ram_raddr;
    logic [rshd_pkg::SUM_W-1:0] ram_wdata, ram_rdata;

    rshd_ram #(
        .WIDTH(rshd_pkg::SUM_W),
        .DEPTH(rshd_pkg::MAX_BINS)
    ) u_sums (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [rshd_pkg::BIN_W-1:0]    bin_reg, bin_next;
    logic [rshd_pkg::WEIGHT_W-1:0] weight_reg;
    logic                          rd_valid_reg;
    logic [rshd_pkg::SUM_W-1:0]    sum_read;
    logic [rshd_pkg::SUM_W:0]      sum_add;
    assign sum_read = rd_valid_reg ? ram_rdata : '0;
    assign sum_add  = {1'b0, sum_read} + (rshd_pkg::SUM_W+1)'(weight_reg);

    // Emit datapath registers.
    logic [rshd_pkg::SUM_W-1:0]    cnt_reg;
    logic [rshd_pkg::RADIUS_W-1:0] rlo_reg, rhi_reg;
    logic [2*rshd_pkg::RADIUS_W-1:0] sqlo_reg, sqhi_reg;
    logic [rshd_pkg::CUBE_W-1:0]   diff_reg;
    logic [rshd_pkg::DEN_W-1:0]    den_reg;
    logic [rshd_pkg::NUM_W-1:0]    num_reg;
    logic [rshd_pkg::DEN_W:0]      rem_reg;
    logic [rshd_pkg::DIV_CNT_W:0]  step_reg;
    logic                          qhi_reg, fault_reg;
    logic [rshd_pkg::DENS_W-1:0]   q_reg;
    logic [rshd_pkg::BIN_W-1:0]    obin_reg;
    logic                          olast_reg;

    logic [rshd_pkg::SUM_W+1:0] cnt3;
    assign cnt3 = {cnt_reg, 1'b0} + (rshd_pkg::SUM_W+2)'(cnt_reg);

    // Shared multiplier: low half of the volume difference first, then the high half.
    logic [rshd_pkg::HALF_W-1:0]                 diff_half;
    logic [rshd_pkg::HALF_W+rshd_pkg::AREA_W-1:0] den_part;
    assign diff_half = (state_reg == ST_DEN2) ? diff_reg[rshd_pkg::CUBE_W-1:rshd_pkg::HALF_W]
                                              : diff_reg[rshd_pkg::HALF_W-1:0];
    assign den_part  = diff_half * sky_area_reg;

    // One divider step: shift in the next numerator bit and try a subtract.
    logic [rshd_pkg::DEN_W+1:0] rem_sh, rem_sub;
    assign rem_sh  = {rem_reg, num_reg[rshd_pkg::NUM_W-1]};
    assign rem_sub = rem_sh - (rshd_pkg::DEN_W+2)'(den_reg);

    logic last_bin;
    assign last_bin = ((rshd_pkg::COUNT_W'(bin_reg) + 1'b1) == nb);

    always_comb begin
        state_next = state_reg;
        bin_next   = bin_reg;
        ram_we     = 1'b0;
        ram_waddr  = bin_reg;
        ram_wdata  = sum_add[rshd_pkg::SUM_W] ? '1 : sum_add[rshd_pkg::SUM_W-1:0];
        ram_raddr  = bin_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        rshd_pkg::CMD_ADD: begin
                            if (hit) begin
                                bin_next   = hit_bin;
                                ram_raddr  = hit_bin;
                                state_next = ST_ARD;
                            end
                        end
                        rshd_pkg::CMD_EMIT: begin
                            bin_next   = '0;
                            ram_raddr  = '0;
                            state_next = ST_ERD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ARD:   state_next = ST_AWR;
            ST_AWR: begin
                ram_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_ERD:   state_next = ST_CUBE1;
            ST_CUBE1: state_next = ST_CUBE2;
            ST_CUBE2: state_next = ST_DEN;
            ST_DEN:   state_next = ST_DEN2;
            ST_DEN2:  state_next = ST_DIV;
            ST_DIV: begin
                if (step_reg == (rshd_pkg::DIV_CNT_W+1)'(rshd_pkg::NUM_W - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid || m_tready) begin
                    if (last_bin) begin
                        state_next = ST_WAIT;
                    end else begin
                        bin_next   = bin_reg + 1'b1;
                        ram_raddr  = bin_reg + 1'b1;
                        state_next = ST_ERD;
                    end
                end
            end
            ST_WAIT:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sky_area_reg  <= rshd_pkg::SKY_AREA_RESET;
            bin_count_reg <= rshd_pkg::BIN_COUNT_RESET;
            valid_reg     <= '0;
            m_tvalid      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    rshd_pkg::CFG_SKY_AREA:  sky_area_reg  <= cfg_data;
                    rshd_pkg::CFG_BIN_COUNT: bin_count_reg <= cfg_data[rshd_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (ram_we) begin
                valid_reg[bin_reg] <= 1'b1;
            end
            if (state_reg == ST_WAIT) begin
                valid_reg <= '0;
            end
            // A new result loads the output register; an accepted one empties it.
            if (state_reg == ST_OUT && (!m_tvalid || m_tready)) begin
                m_tvalid <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        bin_reg      <= bin_next;
        rd_valid_reg <= valid_reg[ram_raddr];
        if (accept && in_cmd == rshd_pkg::CMD_LOAD &&
            in_slot <= rshd_pkg::SLOT_W'(rshd_pkg::MAX_BINS)) begin
            edge_reg[in_slot[rshd_pkg::BIN_W:0]] <= in_edge;
        end
        if (accept) begin
            weight_reg <= in_weight;
        end
        case (state_reg)
            ST_ERD: begin
                cnt_reg <= sum_read;
                rlo_reg <= edge_reg[bin_reg];
                rhi_reg <= edge_reg[rshd_pkg::BIN_W'(bin_reg) + (rshd_pkg::BIN_W+1)'(1)];
            end
            ST_CUBE1: begin
                sqlo_reg <= rlo_reg * rlo_reg;
                sqhi_reg <= rhi_reg * rhi_reg;
            end
            ST_CUBE2: begin
                diff_reg <= rshd_pkg::CUBE_W'(sqhi_reg) * rshd_pkg::CUBE_W'(rhi_reg)
                          - rshd_pkg::CUBE_W'(sqlo_reg) * rshd_pkg::CUBE_W'(rlo_reg);
                // Numerator is three times the count scaled by 2^76.
                num_reg  <= {2'b00, cnt3, 76'd0};
                fault_reg <= (rhi_reg <= rlo_reg) || (sky_area_reg == '0);
            end
            ST_DEN: begin
                den_reg  <= rshd_pkg::DEN_W'(den_part);
                rem_reg  <= '0;
                step_reg <= '0;
                qhi_reg  <= 1'b0;
            end
            ST_DEN2: begin
                den_reg  <= den_reg + {den_part, {rshd_pkg::HALF_W{1'b0}}};
            end
            ST_DIV: begin
                num_reg  <= {num_reg[rshd_pkg::NUM_W-2:0], 1'b0};
                step_reg <= step_reg + 1'b1;
                q_reg    <= {q_reg[rshd_pkg::DENS_W-2:0], ~rem_sub[rshd_pkg::DEN_W+1]};
                if (!rem_sub[rshd_pkg::DEN_W+1]) begin
                    rem_reg <= rem_sub[rshd_pkg::DEN_W:0];
                    if (step_reg < (rshd_pkg::DIV_CNT_W+1)'(rshd_pkg::DENS_W)) begin
                        qhi_reg <= 1'b1;
                    end
                end else begin
                    rem_reg <= rem_sh[rshd_pkg::DEN_W:0];
                end
            end
            default: ;
        endcase
        if (state_reg == ST_OUT && (!m_tvalid || m_tready)) begin
            obin_reg  <= bin_reg;
            olast_reg <= last_bin;
            m_tuser   <= fault_reg || qhi_reg;
            m_tdata   <= {3'd0, ((fault_reg || qhi_reg) ? {rshd_pkg::DENS_W{1'b1}} : q_reg),
                          bin_reg};
        end
    end
    assign m_tlast = olast_reg;

    // Assertions.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("ready while busy");
    a_write_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> $past(state_reg) == ST_ARD) else $error("write without read");
    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT) |=> (valid_reg == '0)) else $error("counts not cleared");
    a_out_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (rshd_pkg::COUNT_W'(obin_reg) < nb)) else $error("bin out of range");
endmodule

### test/rshd_checker.sv
// Checker that predicts the shell densities of the histogram and compares every result item.
module rshd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          pending,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [rshd_pkg::BIN_W-1:0]  bin;
        logic [rshd_pkg::DENS_W-1:0] density;
        logic                        fault;
        logic                        last;
    } shell_result_t;

    // Predicted block state.
    logic [rshd_pkg::AREA_W-1:0]   area;
    logic [rshd_pkg::COUNT_W-1:0]  bins_reg;
    logic [rshd_pkg::RADIUS_W-1:0] edges [0:rshd_pkg::MAX_BINS];
    logic [rshd_pkg::SUM_W-1:0]    sums  [0:rshd_pkg::MAX_BINS-1];

    shell_result_t density_queue[$];

    function automatic int active_bins();
        if (bins_reg == 0) return 1;
        if (bins_reg > rshd_pkg::MAX_BINS) return rshd_pkg::MAX_BINS;
        return int'(bins_reg);
    endfunction

    // Density of one shell: floor(3 * count * 2^76 / ((hi^3 - lo^3) * area)).
    function automatic shell_result_t shell_density(int i, int nb);
        shell_result_t r;
        logic [127:0] lo, hi, vol, den, num, quo;
        lo = 128'(edges[i]);
        hi = 128'(edges[i+1]);
        r.bin = rshd_pkg::BIN_W'(i);
        r.last = (i + 1 == nb);
        if (hi <= lo || area == 0) begin
            r.density = '1;
            r.fault = 1'b1;
            return r;
        end
        vol = hi * hi * hi - lo * lo * lo;
        den = vol * 128'(area);
        num = (128'(sums[i]) * 128'd3) << 76;
        quo = num / den;
        if (quo[127:64] != 0) begin
            r.density = '1;
            r.fault = 1'b1;
        end else begin
            r.density = quo[63:0];
            r.fault = 1'b0;
        end
        return r;
    endfunction

    assign pending = density_queue.size();

    always @(posedge aclk) begin
        logic [1:0]                    cmd;
        logic [rshd_pkg::SLOT_W-1:0]   slot;
        logic [rshd_pkg::RADIUS_W-1:0] radius;
        logic [rshd_pkg::WEIGHT_W-1:0] weight;
        logic [rshd_pkg::SUM_W:0]      total;
        shell_result_t                 exp_r;
        int                            nb;
        if (!aresetn) begin
            area <= rshd_pkg::SKY_AREA_RESET;
            bins_reg <= rshd_pkg::BIN_COUNT_RESET;
            for (int i = 0; i < rshd_pkg::MAX_BINS; i++) sums[i] <= '0;
            density_queue.delete();
            mismatches <= 0;
            results_seen <= 0;
        end else begin
            // Compare an accepted result item with the oldest prediction.
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (density_queue.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result item bin %0d",
                                 $realtime, m_tdata[4:0]);
                    mismatches <= mismatches + 1;
                end else begin
                    exp_r = density_queue.pop_front();
                    if (m_tdata[4:0] !== exp_r.bin || m_tdata[68:5] !== exp_r.density ||
                        m_tdata[71:69] !== 3'b0 || m_tuser !== exp_r.fault ||
                        m_tlast !== exp_r.last) begin
                        if (mismatches < 10)
                            $display({"%0t: bin exp %0d got %0d, density exp %h got %h, ",
                                      "fault exp %b got %b, last exp %b got %b"},
                                     $realtime, exp_r.bin, m_tdata[4:0], exp_r.density,
                                     m_tdata[68:5], exp_r.fault, m_tuser, exp_r.last,
                                     m_tlast);
                        mismatches <= mismatches + 1;
                    end
                end
            end

            // Register writes.
            if (cfg_we) begin
                if (cfg_index == rshd_pkg::CFG_SKY_AREA) area <= cfg_data;
                else bins_reg <= cfg_data[rshd_pkg::COUNT_W-1:0];
            end

            // Update the predicted state for an accepted input item.
            if (s_tvalid && s_tready) begin
                cmd    = s_tdata[1:0];
                slot   = s_tdata[7:2];
                radius = s_tdata[47:28];
                weight = s_tdata[71:48];
                nb     = active_bins();
                if (cmd == rshd_pkg::CMD_LOAD) begin
                    if (slot <= rshd_pkg::MAX_BINS) edges[slot] <= s_tdata[27:8];
                end else if (cmd == rshd_pkg::CMD_ADD) begin
                    if (radius >= edges[0]) begin
                        for (int i = 0; i < nb; i++) begin
                            if (radius < edges[i+1]) begin
                                total = sums[i] + weight;
                                sums[i] <= total[rshd_pkg::SUM_W] ? '1
                                                                  : total[rshd_pkg::SUM_W-1:0];
                                break;
                            end
                        end
                    end
                end else if (cmd == rshd_pkg::CMD_EMIT) begin
                    for (int i = 0; i < nb; i++) density_queue.push_back(shell_density(i, nb));
                    for (int i = 0; i < rshd_pkg::MAX_BINS; i++) sums[i] <= '0;
                end
            end
        end
    end
endmodule

### test/tb.sv
// Testbench top: stimulus, flow control and verdict for the radial shell density histogram.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = rshd_pkg::CFG_SKY_AREA;
    logic [31:0] cfg_data = '0;
    int          mismatches, pending, results_seen;

    // Stimulus copy of the edges, used only to aim galaxy radii at bins.
    logic [rshd_pkg::RADIUS_W-1:0] edge_copy [0:rshd_pkg::MAX_BINS];
    int                  nb_now;
    int                  items_sent = 0;
    int                  emits_sent = 0;
    int                  idle_cycles = 0;
    bit                  long_hold_req = 1'b0;
    bit                  long_hold_done = 1'b0;

    always #10 aclk = ~aclk;

    radial_shell_density_histogram DUT (.*);

    rshd_checker checker_i (.*);

    // Watchdog on cycles without any accepted item.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 40000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, one long hold-off while the sender keeps offering items.
    always begin
        int hold;
        @(posedge aclk);
        if (aresetn && long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            m_tready <= 1'b0;
            repeat (3000) @(posedge aclk);
        end
        hold = gap_len();
        if (hold > 0) begin
            m_tready <= 1'b0;
            repeat (hold) @(posedge aclk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge aclk);
    end

    task automatic send_item(input logic [1:0] cmd, input logic [5:0] slot,
                             input logic [19:0] er, input logic [19:0] gr,
                             input logic [23:0] gw);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {gw, gr, er, slot, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (cmd == rshd_pkg::CMD_EMIT) emits_sent++;
    endtask

    task automatic load_edge(input int slot, input logic [19:0] r);
        send_item(rshd_pkg::CMD_LOAD, 6'(slot), r, 20'($urandom), 24'($urandom));
        if (slot <= rshd_pkg::MAX_BINS) edge_copy[slot] = r;
    endtask

    task automatic add_galaxy(input logic [19:0] r, input logic [23:0] w);
        send_item(rshd_pkg::CMD_ADD, 6'($urandom), 20'($urandom), r, w);
    endtask

    task automatic emit_all();
        send_item(rshd_pkg::CMD_EMIT, 6'($urandom), 20'($urandom), 20'($urandom),
                  24'($urandom));
    endtask

    // Sender pause: every expected result in, then let the block settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_config(input logic [31:0] area, input logic [5:0] bin_cnt);
        cfg_we <= 1'b1;
        cfg_index <= rshd_pkg::CFG_SKY_AREA;
        cfg_data <= area;
        @(posedge aclk);
        cfg_index <= rshd_pkg::CFG_BIN_COUNT;
        cfg_data <= {26'($urandom), bin_cnt};
        @(posedge aclk);
        cfg_we <= 1'b0;
        nb_now = (bin_cnt == 0) ? 1 :
                 (bin_cnt > rshd_pkg::MAX_BINS) ? rshd_pkg::MAX_BINS : int'(bin_cnt);
    endtask

    // Ascending edges starting at base with random steps up to max_step, capped at 1048575.
    task automatic load_ramp(input int base, input int max_step);
        int r;
        r = base;
        for (int s = 0; s <= rshd_pkg::MAX_BINS; s++) begin
            load_edge(s, 20'(r));
            r += $urandom_range(1, max_step);
            if (r > 1048575) r = 1048575;
        end
    endtask

    // Radius inside a random bin in use, sometimes anywhere.
    function automatic logic [19:0] pick_radius();
        int b;
        if ($urandom_range(0, 9) == 0) return 20'($urandom);
        b = $urandom_range(0, nb_now - 1);
        if (edge_copy[b+1] <= edge_copy[b]) return edge_copy[b];
        return 20'($urandom_range(edge_copy[b], edge_copy[b+1] - 1));
    endfunction

    task automatic run_phase(input int n_items);
        int p;
        for (int k = 0; k < n_items; k++) begin
            p = $urandom_range(0, 99);
            if (p < 80) add_galaxy(pick_radius(), 24'($urandom));
            else if (p < 88) emit_all();
            else if (p < 94) load_edge($urandom_range(0, 63), 20'($urandom));
            else if (p < 97) send_item(rshd_pkg::CMD_UNUSED, 6'($urandom), 20'($urandom),
                                       20'($urandom), 24'($urandom));
            else add_galaxy(20'($urandom), 24'hFFFFFF);
        end
        emit_all();
    endtask

    initial begin
        logic [31:0] areas [0:3];
        logic [5:0]  bcounts [0:5];
        areas = '{rshd_pkg::SKY_AREA_RESET, 32'd1, 32'hFFFFFFFF, 32'd0};
        bcounts = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd7, 6'd33};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: reset configuration, full edge table, boundary galaxies.
        nb_now = rshd_pkg::MAX_BINS;
        load_ramp($urandom_range(1, 2000), 30000);
        add_galaxy(edge_copy[0] - 1, 24'hFFFFFF);
        add_galaxy(edge_copy[0], 24'hFFFFFF);
        add_galaxy(edge_copy[1] - 1, 24'h000001);
        add_galaxy(edge_copy[1], 24'h800000);
        add_galaxy(edge_copy[rshd_pkg::MAX_BINS] - 1, 24'hFFFFFF);
        add_galaxy(edge_copy[rshd_pkg::MAX_BINS], 24'hFFFFFF);
        add_galaxy(20'hFFFFF, 24'hFFFFFF);
        add_galaxy(20'h0, 24'h0);
        load_edge(33, 20'hFFFFF);
        load_edge(63, 20'h0);
        send_item(rshd_pkg::CMD_UNUSED, 6'h3F, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF);
        emit_all();
        emit_all();
        wait_idle();

        // Tiny adjacent edges make the quotient overflow; a flat and a falling shell.
        set_config(32'hFFFFFFFF, 6'd8);
        load_edge(0, 20'd0);
        load_edge(1, 20'd1);
        load_edge(2, 20'd1);
        load_edge(3, 20'd0);
        load_edge(4, 20'd5);
        add_galaxy(20'd0, 24'hFFFFFF);
        add_galaxy(20'd4, 24'h000001);
        emit_all();
        wait_idle();

        // Random phases over several register settings.
        for (int ph = 0; ph < 10; ph++) begin
            set_config((ph < 4) ? areas[ph] : 32'($urandom), bcounts[ph % 6]);
            if (ph % 3 == 0) load_ramp($urandom_range(0, 50000), 30000);
            else if (ph % 3 == 1) load_ramp($urandom_range(0, 20), 40);
            run_phase(6);
            wait_idle();
        end

        // Final phase with the long receiver hold-off while items keep coming.
        set_config(rshd_pkg::SKY_AREA_RESET, rshd_pkg::BIN_COUNT_RESET);
        long_hold_req = 1'b1;
        while (items_sent < 370) begin
            run_phase(10);
        end
        wait_idle();

        $display("Sent %0d input items including %0d emits; checked %0d density items.",
                 items_sent, emits_sent, results_seen);
        $display("Covered overflow, flat and falling shells, zero sky area, bin count limits");
        $display("and a long receiver stall with the input held off.");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

### sim.f
sv/rshd_pkg.sv
sv/rshd_ram.sv
sv/radial_shell_density_histogram.sv
test/rshd_checker.sv
test/tb.sv
